@@ rtl/bsh_pkg.sv @@
package bsh_pkg;

   localparam int FRAME_COUNT     = 64;
   localparam int BONES_PER_FRAME = 8;
   localparam int FRAME_W   = $clog2(FRAME_COUNT);
   localparam int BONE_W    = (BONES_PER_FRAME > 1) ? $clog2(BONES_PER_FRAME) : 1;
   localparam int CNT_W     = $clog2(BONES_PER_FRAME + 1);
   localparam int ADDR_W    = FRAME_W + BONE_W;
   localparam int STORE_DEPTH = FRAME_COUNT * (1 << BONE_W);

   localparam int C_W = 16;   // coordinate field
   localparam int E_W = 4 * C_W;
   localparam int W_W = 18;   // world point
   localparam int D_W = 17;   // bone and query direction
   localparam int Q_W = 19;   // query start relative to bone start
   localparam int P_W = 36;   // one product of a cross term
   localparam int X_W = 37;   // cross product
   localparam int N_W = 56;   // numerator of the point
   localparam int H_W = N_W - C_W;
   localparam int DIV_STEPS = C_W;
   localparam int STEP_W = $clog2(DIV_STEPS);

   localparam logic [1:0] ST_MISS   = 2'd0;
   localparam logic [1:0] ST_HIT    = 2'd1;
   localparam logic [1:0] ST_STORED = 2'd2;
   localparam logic [1:0] ST_FULL   = 2'd3;

   localparam logic KIND_LOAD = 1'b0;

   typedef logic [1:0] status_type;

endpackage

@@ rtl/bone_segment_hit_test_core.sv @@
// channel | direction | transfer contents
// req     | in        | kind, frame, first_piece, p0, p1, mirrored, origin
// rsp     | out       | status, point_x, point_y (one per req transfer)
//
// a load goes from the count read to the result register; a query reads
// and tests the bones of its frame one after another until one hits, and a
// hit then runs the point through the 16-step quotient unit.
// the next req transfer can be taken the cycle after the result register loads.
// reset (synchronous) clears the per-frame count valid bits; the bone store
// is never cleared. req_stall is high during reset, while an item is in work
// or while its result cannot yet move into the output register; rsp holds
// while rsp_stall is high.
module bone_segment_hit_test_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_kind,
   input  logic [5:0]           req_frame,
   input  logic                 req_first_piece,
   input  logic signed [15:0]   req_p0_x,
   input  logic signed [15:0]   req_p0_y,
   input  logic signed [15:0]   req_p1_x,
   input  logic signed [15:0]   req_p1_y,
   input  logic                 req_mirrored,
   input  logic signed [15:0]   req_origin_x,
   input  logic signed [15:0]   req_origin_y,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [1:0]           rsp_status,
   output logic signed [15:0]   rsp_point_x,
   output logic signed [15:0]   rsp_point_y
);

   // sequencer codes
   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_CNT  = 4'd1;
   localparam logic [3:0] S_RD   = 4'd2;
   localparam logic [3:0] S_MUL1 = 4'd3;
   localparam logic [3:0] S_DIFF = 4'd4;
   localparam logic [3:0] S_TEST = 4'd5;
   localparam logic [3:0] S_MUL2 = 4'd6;
   localparam logic [3:0] S_SUM  = 4'd7;
   localparam logic [3:0] S_DIVI = 4'd8;
   localparam logic [3:0] S_DIV  = 4'd9;
   localparam logic [3:0] S_SAT  = 4'd10;
   localparam logic [3:0] S_OUT  = 4'd11;

   localparam int FW = bsh_pkg::FRAME_W;
   localparam int BW = bsh_pkg::BONE_W;
   localparam int CW = bsh_pkg::CNT_W;

   logic [3:0] state_ff, state_in;

   // memories: bone store and per-frame counts
   logic [bsh_pkg::E_W-1:0] store_mem [0:bsh_pkg::STORE_DEPTH-1];
   logic [CW-1:0]           cnt_mem [0:bsh_pkg::FRAME_COUNT-1];
   logic [bsh_pkg::FRAME_COUNT-1:0] cnt_vld_ff;

   logic [bsh_pkg::E_W-1:0] st_rd_ff;
   logic                    st_we, st_re;
   logic [bsh_pkg::ADDR_W-1:0] st_wa, st_ra;
   logic [CW-1:0]           cnt_rd_ff;
   logic                    cnt_hit_ff;

   // item registers
   logic                kind_ff, first_ff, mir_ff;
   logic [FW-1:0]       frame_ff;
   logic signed [15:0]  cx_ff, cy_ff, dx_ff, dy_ff, ox_ff, oy_ff;
   logic signed [bsh_pkg::D_W-1:0] sx_ff, sy_ff;
   logic [CW-1:0]       cnt_ff;
   logic [BW-1:0]       idx_ff;

   // per-bone datapath registers
   logic signed [bsh_pkg::W_W-1:0] ax_ff, ay_ff;
   logic signed [bsh_pkg::D_W-1:0] rx_ff, ry_ff;
   logic signed [bsh_pkg::Q_W-1:0] qx_ff, qy_ff;
   logic signed [bsh_pkg::P_W-1:0] m0_ff, m1_ff, m2_ff, m3_ff, m4_ff, m5_ff;
   logic signed [bsh_pkg::X_W-1:0] den_ff, tn_ff, un_ff;
   logic signed [bsh_pkg::N_W-1:0] pxa_ff, pxb_ff, pya_ff, pyb_ff;

   // quotient unit, x and y side by side
   logic [bsh_pkg::N_W-1:0] nxa_ff, nya_ff;
   logic                    nxs_ff, nys_ff, ovx_ff, ovy_ff;
   logic [bsh_pkg::X_W-1:0] rmx_ff, rmy_ff;
   logic [15:0]             qx16_ff, qy16_ff;
   logic [bsh_pkg::STEP_W-1:0] step_ff;

   // result holding and output register
   bsh_pkg::status_type res_status_ff;
   logic signed [15:0]  res_px_ff, res_py_ff;
   logic                rsp_valid_ff;
   bsh_pkg::status_type rsp_status_ff;
   logic signed [15:0]  rsp_px_ff, rsp_py_ff;

   logic req_take, out_free;
   assign req_stall = reset || (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_point_x = rsp_px_ff;
   assign rsp_point_y = rsp_py_ff;

   // count seen at the first work cycle, never-written frames read as zero
   logic [CW-1:0] cnt_eff, load_slot;
   logic          load_full;
   assign cnt_eff   = cnt_hit_ff ? cnt_rd_ff : '0;
   assign load_slot = first_ff ? '0 : cnt_eff;
   assign load_full = (load_slot >= CW'(bsh_pkg::BONES_PER_FRAME));

   // bone miss test on normalized terms
   logic bone_miss, last_bone;
   assign bone_miss = (den_ff == 0) || (tn_ff < 0) || (tn_ff > den_ff) ||
                      (un_ff < 0) || (un_ff > den_ff);
   assign last_bone = ((CW'(idx_ff) + CW'(1)) == cnt_ff);

   always_comb begin
      st_we = (state_ff == S_CNT) && (kind_ff == bsh_pkg::KIND_LOAD) && !load_full;
      st_wa = {frame_ff, load_slot[BW-1:0]};
      st_re = 1'b0;
      st_ra = {frame_ff, idx_ff + BW'(1)};
      if (state_ff == S_CNT) begin
         st_re = (kind_ff != bsh_pkg::KIND_LOAD) && (cnt_eff != 0);
         st_ra = {frame_ff, {BW{1'b0}}};
      end else if (state_ff == S_TEST) begin
         st_re = bone_miss && !last_bone;
      end
   end

   always_ff @(posedge clock) begin
      if (st_we) begin
         store_mem[st_wa] <= {dy_ff, dx_ff, cy_ff, cx_ff};
      end
      if (st_re) begin
         st_rd_ff <= store_mem[st_ra];
      end
      if (st_we) begin
         cnt_mem[frame_ff] <= load_slot + CW'(1);
      end
      if (req_take) begin
         cnt_rd_ff  <= cnt_mem[req_frame];
         cnt_hit_ff <= cnt_vld_ff[req_frame];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_vld_ff <= '0;
      end else if (st_we) begin
         cnt_vld_ff[frame_ff] <= 1'b1;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (req_take) state_in = S_CNT;
         S_CNT: begin
            if (kind_ff == bsh_pkg::KIND_LOAD || cnt_eff == 0) state_in = S_OUT;
            else state_in = S_RD;
         end
         S_RD:   state_in = S_MUL1;
         S_MUL1: state_in = S_DIFF;
         S_DIFF: state_in = S_TEST;
         S_TEST: begin
            if (!bone_miss) state_in = S_MUL2;
            else if (last_bone) state_in = S_OUT;
            else state_in = S_RD;
         end
         S_MUL2: state_in = S_SUM;
         S_SUM:  state_in = S_DIVI;
         S_DIVI: state_in = S_DIV;
         S_DIV:  if (step_ff == bsh_pkg::STEP_W'(bsh_pkg::DIV_STEPS - 1)) state_in = S_SAT;
         S_SAT:  state_in = S_OUT;
         S_OUT:  if (out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   // per-bone combinational front end
   logic signed [bsh_pkg::W_W-1:0] a0x, a0y, b0x, b0y, wax, way;
   logic signed [bsh_pkg::D_W-1:0] drx, dry;
   assign a0x = bsh_pkg::W_W'($signed(st_rd_ff[15:0]));
   assign a0y = bsh_pkg::W_W'($signed(st_rd_ff[31:16]));
   assign b0x = bsh_pkg::W_W'($signed(st_rd_ff[47:32]));
   assign b0y = bsh_pkg::W_W'($signed(st_rd_ff[63:48]));
   assign wax = mir_ff ? (bsh_pkg::W_W'(ox_ff) - a0x) : (bsh_pkg::W_W'(ox_ff) + a0x);
   assign way = bsh_pkg::W_W'(oy_ff) + a0y;
   assign drx = mir_ff ? bsh_pkg::D_W'(a0x - b0x) : bsh_pkg::D_W'(b0x - a0x);
   assign dry = bsh_pkg::D_W'(b0y - a0y);

   logic signed [bsh_pkg::X_W-1:0] den_raw, tn_raw, un_raw;
   assign den_raw = bsh_pkg::X_W'(m0_ff) - bsh_pkg::X_W'(m1_ff);
   assign tn_raw  = bsh_pkg::X_W'(m2_ff) - bsh_pkg::X_W'(m3_ff);
   assign un_raw  = bsh_pkg::X_W'(m4_ff) - bsh_pkg::X_W'(m5_ff);

   logic signed [bsh_pkg::N_W-1:0] pxn, pyn;
   assign pxn = pxa_ff + pxb_ff;
   assign pyn = pya_ff + pyb_ff;

   // quotient steps: shift one numerator bit into the partial remainder
   logic [bsh_pkg::X_W:0] tx, ty;
   logic [bsh_pkg::X_W:0] dn_ext;
   assign dn_ext = {1'b0, den_ff};
   assign tx = {rmx_ff, nxa_ff[bsh_pkg::C_W-1]};
   assign ty = {rmy_ff, nya_ff[bsh_pkg::C_W-1]};

   logic [bsh_pkg::H_W-1:0] hix, hiy;
   assign hix = nxa_ff[bsh_pkg::N_W-1:bsh_pkg::C_W];
   assign hiy = nya_ff[bsh_pkg::N_W-1:bsh_pkg::C_W];

   // truncate toward zero and clamp to 16 bits
   function automatic logic [15:0] clamp16(input logic neg, input logic ov,
                                           input logic [15:0] q);
      logic [15:0] r;
      if (!neg) begin
         r = (ov || q[15]) ? 16'h7FFF : q;
      end else begin
         r = (ov || (q[15] && q[14:0] != 0)) ? 16'h8000 : (16'd0 - q);
      end
      return r;
   endfunction

   always_ff @(posedge clock) begin
      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               kind_ff  <= req_kind;
               frame_ff <= req_frame[FW-1:0];
               first_ff <= req_first_piece;
               mir_ff   <= req_mirrored;
               cx_ff    <= req_p0_x;
               cy_ff    <= req_p0_y;
               dx_ff    <= req_p1_x;
               dy_ff    <= req_p1_y;
               ox_ff    <= req_origin_x;
               oy_ff    <= req_origin_y;
            end
         end
         S_CNT: begin
            sx_ff  <= bsh_pkg::D_W'(dx_ff) - bsh_pkg::D_W'(cx_ff);
            sy_ff  <= bsh_pkg::D_W'(dy_ff) - bsh_pkg::D_W'(cy_ff);
            cnt_ff <= cnt_eff;
            idx_ff <= '0;
            res_px_ff <= '0;
            res_py_ff <= '0;
            if (kind_ff == bsh_pkg::KIND_LOAD) begin
               res_status_ff <= load_full ? bsh_pkg::ST_FULL : bsh_pkg::ST_STORED;
            end else begin
               res_status_ff <= bsh_pkg::ST_MISS;
            end
         end
         S_RD: begin
            ax_ff <= wax;
            ay_ff <= way;
            rx_ff <= drx;
            ry_ff <= dry;
            qx_ff <= bsh_pkg::Q_W'(cx_ff) - bsh_pkg::Q_W'(wax);
            qy_ff <= bsh_pkg::Q_W'(cy_ff) - bsh_pkg::Q_W'(way);
         end
         S_MUL1: begin
            m0_ff <= bsh_pkg::P_W'(rx_ff * sy_ff);
            m1_ff <= bsh_pkg::P_W'(ry_ff * sx_ff);
            m2_ff <= bsh_pkg::P_W'(qx_ff * sy_ff);
            m3_ff <= bsh_pkg::P_W'(qy_ff * sx_ff);
            m4_ff <= bsh_pkg::P_W'(qx_ff * ry_ff);
            m5_ff <= bsh_pkg::P_W'(qy_ff * rx_ff);
         end
         S_DIFF: begin
            // make the denominator positive
            if (den_raw < 0) begin
               den_ff <= -den_raw;
               tn_ff  <= -tn_raw;
               un_ff  <= -un_raw;
            end else begin
               den_ff <= den_raw;
               tn_ff  <= tn_raw;
               un_ff  <= un_raw;
            end
         end
         S_TEST: begin
            if (bone_miss && !last_bone) idx_ff <= idx_ff + BW'(1);
         end
         S_MUL2: begin
            pxa_ff <= bsh_pkg::N_W'(ax_ff * den_ff);
            pxb_ff <= bsh_pkg::N_W'(tn_ff * rx_ff);
            pya_ff <= bsh_pkg::N_W'(ay_ff * den_ff);
            pyb_ff <= bsh_pkg::N_W'(tn_ff * ry_ff);
         end
         S_SUM: begin
            nxs_ff <= pxn[bsh_pkg::N_W-1];
            nys_ff <= pyn[bsh_pkg::N_W-1];
            nxa_ff <= pxn[bsh_pkg::N_W-1] ? bsh_pkg::N_W'(-pxn) : bsh_pkg::N_W'(pxn);
            nya_ff <= pyn[bsh_pkg::N_W-1] ? bsh_pkg::N_W'(-pyn) : bsh_pkg::N_W'(pyn);
         end
         S_DIVI: begin
            ovx_ff  <= (bsh_pkg::N_W'(hix) >= bsh_pkg::N_W'(den_ff));
            ovy_ff  <= (bsh_pkg::N_W'(hiy) >= bsh_pkg::N_W'(den_ff));
            rmx_ff  <= bsh_pkg::X_W'(hix);
            rmy_ff  <= bsh_pkg::X_W'(hiy);
            step_ff <= '0;
         end
         S_DIV: begin
            if (tx >= dn_ext) begin
               rmx_ff <= bsh_pkg::X_W'(tx - dn_ext);
               qx16_ff <= {qx16_ff[14:0], 1'b1};
            end else begin
               rmx_ff <= bsh_pkg::X_W'(tx);
               qx16_ff <= {qx16_ff[14:0], 1'b0};
            end
            if (ty >= dn_ext) begin
               rmy_ff <= bsh_pkg::X_W'(ty - dn_ext);
               qy16_ff <= {qy16_ff[14:0], 1'b1};
            end else begin
               rmy_ff <= bsh_pkg::X_W'(ty);
               qy16_ff <= {qy16_ff[14:0], 1'b0};
            end
            nxa_ff  <= {nxa_ff[bsh_pkg::N_W-2:0], 1'b0};
            nya_ff  <= {nya_ff[bsh_pkg::N_W-2:0], 1'b0};
            step_ff <= step_ff + bsh_pkg::STEP_W'(1);
         end
         S_SAT: begin
            res_status_ff <= bsh_pkg::ST_HIT;
            res_px_ff <= clamp16(nxs_ff, ovx_ff, qx16_ff);
            res_py_ff <= clamp16(nys_ff, ovy_ff, qy16_ff);
         end
         S_OUT: begin
            if (out_free) begin
               rsp_status_ff <= res_status_ff;
               rsp_px_ff     <= res_px_ff;
               rsp_py_ff     <= res_py_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == S_OUT && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

endmodule

@@ dv/bone_segment_hit_test_core_tb.sv @@
module bone_segment_hit_test_core_tb;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic req_kind;
   logic [5:0] req_frame;
   logic req_first_piece;
   logic signed [15:0] req_p0_x, req_p0_y, req_p1_x, req_p1_y;
   logic req_mirrored;
   logic signed [15:0] req_origin_x, req_origin_y;
   logic rsp_valid;
   logic rsp_stall;
   bsh_pkg::status_type rsp_status;
   logic signed [15:0] rsp_point_x, rsp_point_y;

   bone_segment_hit_test_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_kind(req_kind), .req_frame(req_frame), .req_first_piece(req_first_piece),
      .req_p0_x(req_p0_x), .req_p0_y(req_p0_y), .req_p1_x(req_p1_x), .req_p1_y(req_p1_y),
      .req_mirrored(req_mirrored), .req_origin_x(req_origin_x), .req_origin_y(req_origin_y),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_status(rsp_status), .rsp_point_x(rsp_point_x), .rsp_point_y(rsp_point_y)
   );

   // one input transfer
   typedef struct {
      logic kind;
      logic [5:0] frame;
      logic first_piece;
      logic signed [15:0] p0_x, p0_y, p1_x, p1_y;
      logic mirrored;
      logic signed [15:0] origin_x, origin_y;
   } bone_item_type;

   // one result transfer
   typedef struct {
      bsh_pkg::status_type status;
      logic signed [15:0] point_x, point_y;
   } hit_result_type;

   // directed table row: item plus an optional typed-in answer
   typedef struct {
      bone_item_type item;
      bit has_answer;
      hit_result_type answer;
   } directed_row_type;

   localparam int EXP_DEPTH = 2048;
   localparam int ROW_DEPTH = 64;

   // predictor state: shadow of the bone lists
   logic signed [15:0] bone_x0 [bsh_pkg::FRAME_COUNT][bsh_pkg::BONES_PER_FRAME];
   logic signed [15:0] bone_y0 [bsh_pkg::FRAME_COUNT][bsh_pkg::BONES_PER_FRAME];
   logic signed [15:0] bone_x1 [bsh_pkg::FRAME_COUNT][bsh_pkg::BONES_PER_FRAME];
   logic signed [15:0] bone_y1 [bsh_pkg::FRAME_COUNT][bsh_pkg::BONES_PER_FRAME];
   int unsigned bones_held [bsh_pkg::FRAME_COUNT];

   // expected results in order of transfer
   hit_result_type expect_fifo [EXP_DEPTH];
   int exp_wr = 0;
   int exp_rd = 0;
   int error_count = 0;
   int mismatch_count = 0;
   int sender_idle_pct;
   int receiver_stall_pct;
   directed_row_type directed_rows [ROW_DEPTH];
   int row_count;

   function automatic logic signed [15:0] clamp16(longint v);
      if (v > 32767) return 16'sh7FFF;
      if (v < -32768) return 16'sh8000;
      return v[15:0];
   endfunction

   // expected result of one item, updating the bone list shadow
   function automatic hit_result_type predict_hit(bone_item_type it);
      hit_result_type r;
      int fr;
      int n;
      longint cx, cy, sx, sy, ox, oy;
      longint ax, ay, bx, by, rx, ry, qx, qy, den, tn, un, pxn, pyn;
      fr = it.frame % bsh_pkg::FRAME_COUNT;
      r.status = bsh_pkg::ST_MISS;
      r.point_x = '0;
      r.point_y = '0;
      if (it.kind == bsh_pkg::KIND_LOAD) begin
         if (it.first_piece) bones_held[fr] = 0;
         if (bones_held[fr] >= bsh_pkg::BONES_PER_FRAME) begin
            r.status = bsh_pkg::ST_FULL;
            return r;
         end
         n = bones_held[fr];
         bone_x0[fr][n] = it.p0_x;
         bone_y0[fr][n] = it.p0_y;
         bone_x1[fr][n] = it.p1_x;
         bone_y1[fr][n] = it.p1_y;
         bones_held[fr] = n + 1;
         r.status = bsh_pkg::ST_STORED;
         return r;
      end
      cx = it.p0_x;
      cy = it.p0_y;
      sx = longint'(it.p1_x) - cx;
      sy = longint'(it.p1_y) - cy;
      ox = it.origin_x;
      oy = it.origin_y;
      for (int i = 0; i < bones_held[fr]; i++) begin
         ax = it.mirrored ? ox - bone_x0[fr][i] : ox + bone_x0[fr][i];
         bx = it.mirrored ? ox - bone_x1[fr][i] : ox + bone_x1[fr][i];
         ay = oy + bone_y0[fr][i];
         by = oy + bone_y1[fr][i];
         rx = bx - ax;
         ry = by - ay;
         qx = cx - ax;
         qy = cy - ay;
         den = rx * sy - ry * sx;
         if (den == 0) continue;
         tn = qx * sy - qy * sx;
         un = qx * ry - qy * rx;
         if (den < 0) begin
            den = -den;
            tn = -tn;
            un = -un;
         end
         if (tn < 0 || tn > den || un < 0 || un > den) continue;
         pxn = ax * den + tn * rx;
         pyn = ay * den + tn * ry;
         r.status = bsh_pkg::ST_HIT;
         r.point_x = clamp16(pxn / den);
         r.point_y = clamp16(pyn / den);
         return r;
      end
      return r;
   endfunction

   function automatic bone_item_type make_item(int kind, int frame, int first,
         int x0, int y0, int x1, int y1, int mir, int ox, int oy);
      bone_item_type it;
      it.kind = kind[0];
      it.frame = frame[5:0];
      it.first_piece = first[0];
      it.p0_x = x0[15:0];
      it.p0_y = y0[15:0];
      it.p1_x = x1[15:0];
      it.p1_y = y1[15:0];
      it.mirrored = mir[0];
      it.origin_x = ox[15:0];
      it.origin_y = oy[15:0];
      return it;
   endfunction

   function automatic logic signed [15:0] rand_coord();
      unique case ($urandom_range(0, 5))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         2: return 16'($urandom_range(0, 63) - 32);
         3: return 16'($urandom_range(0, 4095) - 2048);
         default: return 16'($urandom);
      endcase
   endfunction

   // random item; most items go to a small set of frames so queries see full lists
   function automatic bone_item_type rand_item();
      bone_item_type it;
      it.kind = ($urandom_range(0, 99) < 50);
      it.frame = ($urandom_range(0, 9) < 8) ? 6'($urandom_range(0, 3)) : 6'($urandom);
      it.first_piece = ($urandom_range(0, 9) == 0);
      it.p0_x = rand_coord();
      it.p0_y = rand_coord();
      it.p1_x = rand_coord();
      it.p1_y = rand_coord();
      it.mirrored = 1'($urandom);
      // small origins keep world points near the query segments
      it.origin_x = ($urandom_range(0, 3) == 0) ? rand_coord() :
                    16'($urandom_range(0, 255) - 128);
      it.origin_y = ($urandom_range(0, 3) == 0) ? rand_coord() :
                    16'($urandom_range(0, 255) - 128);
      if ($urandom_range(0, 1) != 0) begin
         // crossing query through the origin area, so hits are common
         it.p0_x = 16'($urandom_range(0, 4095) - 2048);
         it.p1_x = 16'(-it.p0_x + $urandom_range(0, 63) - 32);
         it.p0_y = 16'($urandom_range(0, 4095) - 2048);
         it.p1_y = 16'($urandom_range(0, 4095) - 2048);
      end
      return it;
   endfunction

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // receiver side: random stall per the current idling phase
   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
   end

   // compare each result transfer with the oldest expectation
   always @(posedge clock) begin
      hit_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (exp_wr == exp_rd) begin
            error_count++;
            if (mismatch_count < 10)
               $display("unexpected result transfer: status %0d x %0d y %0d",
                        rsp_status, rsp_point_x, rsp_point_y);
            mismatch_count++;
         end else begin
            want = expect_fifo[exp_rd % EXP_DEPTH];
            exp_rd++;
            if (rsp_status !== want.status || rsp_point_x !== want.point_x ||
                rsp_point_y !== want.point_y) begin
               error_count++;
               if (mismatch_count < 10)
                  $display("result mismatch: expected status %0d x %0d y %0d, got %0d %0d %0d",
                           want.status, want.point_x, want.point_y,
                           rsp_status, rsp_point_x, rsp_point_y);
               mismatch_count++;
            end
         end
      end
   end

   // append one expectation
   task automatic put_expect(hit_result_type ans);
      expect_fifo[exp_wr % EXP_DEPTH] = ans;
      exp_wr++;
   endtask

   // drive one item and hold it until the transfer happens; a typed answer
   // replaces the predictor's one as the expectation
   task automatic send_item(bone_item_type it, bit has_ans, hit_result_type ans);
      hit_result_type model_ans;
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= it.kind;
      req_frame <= it.frame;
      req_first_piece <= it.first_piece;
      req_p0_x <= it.p0_x;
      req_p0_y <= it.p0_y;
      req_p1_x <= it.p1_x;
      req_p1_y <= it.p1_y;
      req_mirrored <= it.mirrored;
      req_origin_x <= it.origin_x;
      req_origin_y <= it.origin_y;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      model_ans = predict_hit(it);
      put_expect(has_ans ? ans : model_ans);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (exp_wr != exp_rd) @(posedge clock);
   endtask

   // directed rows; answers typed in only for the obvious ones
   task automatic add_row(bone_item_type it, int has_ans, bsh_pkg::status_type st);
      directed_row_type row;
      row.item = it;
      row.has_answer = (has_ans != 0);
      row.answer.status = st;
      row.answer.point_x = '0;
      row.answer.point_y = '0;
      directed_rows[row_count] = row;
      row_count++;
   endtask

   initial begin
      hit_result_type no_ans;
      no_ans.status = bsh_pkg::ST_MISS;
      no_ans.point_x = '0;
      no_ans.point_y = '0;
      row_count = 0;
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      for (int f = 0; f < bsh_pkg::FRAME_COUNT; f++) bones_held[f] = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_kind = 1'b0;
      req_frame = '0;
      req_first_piece = 1'b0;
      req_p0_x = '0;
      req_p0_y = '0;
      req_p1_x = '0;
      req_p1_y = '0;
      req_mirrored = 1'b0;
      req_origin_x = '0;
      req_origin_y = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // query on an empty frame after reset: no hit
      add_row(make_item(1, 0, 0, -100, 0, 100, 0, 0, 0, 0), 1, bsh_pkg::ST_MISS);
      // load with first piece, then fill to eight, then the dropped ninth
      add_row(make_item(0, 5, 1, 0, -50, 0, 50, 1, 7, 7), 1, bsh_pkg::ST_STORED);
      for (int i = 1; i < bsh_pkg::BONES_PER_FRAME; i++)
         add_row(make_item(0, 5, 0, 10 * i, -40, 10 * i, 40, 0, 0, 0), 1,
                 bsh_pkg::ST_STORED);
      add_row(make_item(0, 5, 0, 1, 2, 3, 4, 0, 0, 0), 1, bsh_pkg::ST_FULL);
      // hit, mirrored hit, parallel miss, endpoint touch
      add_row(make_item(1, 5, 1, -100, 0, 100, 0, 0, 0, 0), 0, bsh_pkg::ST_MISS);
      add_row(make_item(1, 5, 0, -100, 10, 100, 10, 1, 3, -3), 0, bsh_pkg::ST_MISS);
      add_row(make_item(1, 5, 0, 0, -60, 0, 60, 0, 0, 0), 0, bsh_pkg::ST_MISS);
      add_row(make_item(1, 5, 0, 0, 50, 10, 50, 0, 0, 0), 0, bsh_pkg::ST_MISS);
      // first piece on a full list clears it
      add_row(make_item(0, 5, 1, -32768, -32768, 32767, 32767, 0, 0, 0), 1,
              bsh_pkg::ST_STORED);
      // extremes: saturated world points and a point outside 16 bits
      add_row(make_item(1, 5, 0, 32767, -32768, -32768, 32767, 0, 32767, 32767), 0,
              bsh_pkg::ST_MISS);
      add_row(make_item(1, 5, 0, -32768, 32767, 32767, -32768, 1, -32768, -32768), 0,
              bsh_pkg::ST_MISS);
      add_row(make_item(0, 63, 1, -32768, 0, 32767, 0, 0, 0, 0), 1, bsh_pkg::ST_STORED);
      add_row(make_item(1, 63, 0, 0, -32768, 0, 32767, 0, 32767, 0), 0, bsh_pkg::ST_MISS);
      add_row(make_item(1, 63, 0, 1, 1, 1, 1, 0, 0, 0), 0, bsh_pkg::ST_MISS);

      for (int i = 0; i < row_count; i++)
         send_item(directed_rows[i].item, directed_rows[i].has_answer,
                   directed_rows[i].answer);

      // random part over the idling phases; one pause drains everything
      for (int phase = 0; phase < 4; phase++) begin
         unique case (phase)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 51; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 51; end
            default: begin sender_idle_pct = 32; receiver_stall_pct = 32; end
         endcase
         for (int n = 0; n < 310; n++) begin
            if (phase == 1 && n == 150) wait_drained();
            send_item(rand_item(), 1'b0, no_ans);
         end
      end

      wait_drained();
      repeat (100) @(posedge clock);
      if (error_count == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // fixed run limit, far beyond the slowest correct run
   initial begin
      #2000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/bsh_pkg.sv
rtl/bone_segment_hit_test_core.sv
dv/bone_segment_hit_test_core_tb.sv
